// ===== rtl/epsr_pkg.sv =====
// Shared types and constants for the event publish/subscribe router.
// No dependencies; every other file of the block imports this package.
package epsr_pkg;

  // Parameter defaults
  localparam int SUBSCRIBERS_DEF       = 16;
  localparam int QUEUE_DEPTH_DEF       = 16;
  localparam int MAX_PAYLOAD_BYTES_DEF = 8;

  // Deliveries per dispatch are capped at this many
  localparam int RESULT_LIMIT = 16;
  localparam int NCOUNT_W     = $clog2(RESULT_LIMIT + 1);

  // Fixed field widths
  localparam int OP_W   = 3;
  localparam int EV_W   = 8;
  localparam int HDL_W  = 4;
  localparam int PAY_W  = 64;
  localparam int PLEN_W = 8;
  localparam int TAG_W  = 32;
  localparam int ST_W   = 3;
  localparam int SLOT_W = 4;
  localparam int LEN_W  = 4;
  localparam int PEND_W = 4;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SUBSCRIBE   = 3'd0;
  localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = 3'd1;
  localparam logic [OP_W-1:0] OP_PUBLISH     = 3'd2;
  localparam logic [OP_W-1:0] OP_DISPATCH    = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH       = 3'd4;
  localparam logic [OP_W-1:0] OP_STATS       = 3'd5;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd1;
  localparam logic [ST_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [ST_W-1:0] ST_Q_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_SUB     = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // transaction taken on the request channel
    logic disp_start;  // accepted dispatch on a non-empty queue
    logic latch_q;     // capture the popped queue entry
    logic capture;     // hold the current slot as a delivery
    logic scan_inc;    // step to the next subscriber slot
    logic emit_held;   // send the held delivery, not last
    logic emit_final;  // send the final result of a dispatch
  } epsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a transaction
    logic q_empty;    // queue holds no event
    logic no_subs;    // no subscriber slot ever used
    logic match;      // current slot is active and subscribed to the event
    logic have;       // a delivery is held
    logic scan_end;   // current slot is the last one used
    logic cap_last;   // capturing now ends the scan
  } epsr_stat_t;

endpackage

// ===== rtl/epsr_channel_if.sv =====
// Request and result channel interfaces of the event router.
// Depends on epsr_pkg for field widths.
interface epsr_req_if
  import epsr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [EV_W-1:0]   ev_code;
  logic [HDL_W-1:0]  handle;
  logic [PAY_W-1:0]  payload;
  logic [PLEN_W-1:0] len_req;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, op, ev_code, handle, payload, len_req, tag,
                  input ready);
  modport sink (input valid, op, ev_code, handle, payload, len_req, tag,
                output ready);
endinterface

interface epsr_rsp_if
  import epsr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot;
  logic [EV_W-1:0]   out_event_id;
  logic [PAY_W-1:0]  out_payload;
  logic [LEN_W-1:0]  out_length;
  logic [TAG_W-1:0]  out_tag;
  logic              last;
  logic [PEND_W-1:0] pending;
  logic [CNT_W-1:0]  published_count;
  logic [CNT_W-1:0]  dispatched_count;
  logic [CNT_W-1:0]  dropped_count;
  logic [TOT_W-1:0]  subscriber_total;

  modport source (output valid, status, slot, out_event_id, out_payload, out_length,
                  out_tag, last, pending, published_count, dispatched_count,
                  dropped_count, subscriber_total,
                  input ready);
  modport sink (input valid, status, slot, out_event_id, out_payload, out_length,
                out_tag, last, pending, published_count, dispatched_count,
                dropped_count, subscriber_total,
                output ready);
endinterface

// ===== rtl/epsr_ctrl.sv =====
// Controller of the event router: sequences accept, queue pop, table scan
// and result emission. Depends on epsr_pkg.
module epsr_ctrl
  import epsr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_op,
  output logic            req_ready,
  input  epsr_stat_t      stat,
  output epsr_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_QRD  = 6'b000010,
    S_SRD  = 6'b000100,
    S_SCMP = 6'b001000,
    S_EMIT = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE) && stat.out_free;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.accept = 1'b1;
          if (req_op == OP_DISPATCH && !stat.q_empty) begin
            cmd.disp_start = 1'b1;
            state_next     = S_QRD;
          end
        end
      end
      S_QRD: begin
        cmd.latch_q = 1'b1;
        state_next  = stat.no_subs ? S_FIN : S_SRD;
      end
      S_SRD: begin
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match && stat.have) begin
          state_next = S_EMIT;
        end else if (stat.match) begin
          cmd.capture = 1'b1;
          if (stat.cap_last) begin
            state_next = S_FIN;
          end else begin
            cmd.scan_inc = 1'b1;
            state_next   = S_SRD;
          end
        end else if (stat.scan_end) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SRD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_held = 1'b1;
          cmd.capture   = 1'b1;
          if (stat.cap_last) begin
            state_next = S_FIN;
          end else begin
            cmd.scan_inc = 1'b1;
            state_next   = S_SRD;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/epsr_dpath.sv =====
// Datapath of the event router: subscriber table, event ring, counters and
// the result register. Depends on epsr_pkg and epsr_rsp_if.
module epsr_dpath
  import epsr_pkg::*;
#(
  parameter int SUBSCRIBERS       = SUBSCRIBERS_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [OP_W-1:0]   op,
  input  logic [EV_W-1:0]   ev_code,
  input  logic [HDL_W-1:0]  handle,
  input  logic [PAY_W-1:0]  payload,
  input  logic [PLEN_W-1:0] len_req,
  input  logic [TAG_W-1:0]  tag,
  input  epsr_cmd_t         cmd,
  output epsr_stat_t        stat,
  epsr_rsp_if.source        rsp
);

  localparam int SW = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int UW = $clog2(SUBSCRIBERS + 1);
  localparam int QW = $clog2(QUEUE_DEPTH);

  // Subscriber table
  logic [EV_W-1:0]        sub_event [SUBSCRIBERS];
  logic [TAG_W-1:0]       sub_tag   [SUBSCRIBERS];
  logic [SUBSCRIBERS-1:0] sub_active;
  logic [UW-1:0]          slots_used;

  // Event ring
  logic [EV_W-1:0]  queue_event   [QUEUE_DEPTH];
  logic [PAY_W-1:0] queue_payload [QUEUE_DEPTH];
  logic [LEN_W-1:0] queue_length  [QUEUE_DEPTH];
  logic [QW-1:0]    write_index;
  logic [QW-1:0]    read_index;

  logic [CNT_W-1:0] count_published;
  logic [CNT_W-1:0] count_dispatched;
  logic [CNT_W-1:0] count_dropped;

  // Scan and held delivery
  logic [SW-1:0]       scan_i;
  logic [EV_W-1:0]     sub_ev_q;
  logic [TAG_W-1:0]    sub_tag_q;
  logic [EV_W-1:0]     q_ev_q;
  logic [PAY_W-1:0]    q_pay_q;
  logic [LEN_W-1:0]    q_len_q;
  logic [EV_W-1:0]     ev_l;
  logic [PAY_W-1:0]    pay_l;
  logic [LEN_W-1:0]    len_l;
  logic [SW-1:0]       held_slot;
  logic [TAG_W-1:0]    held_tag;
  logic                have;
  logic [NCOUNT_W-1:0] n_cnt;

  // Result register
  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [EV_W-1:0]   out_ev;
  logic [PAY_W-1:0]  out_pay;
  logic [LEN_W-1:0]  out_len;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_last;

  // Decode
  logic          do_sub, do_unsub, do_pub, do_disp, do_flush, do_stats, simple_load;
  logic [QW-1:0] wr_nxt, rd_nxt;
  logic          q_full, q_empty;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic          table_full;
  logic [SW-1:0] new_slot;
  logic          handle_ok;
  logic [LEN_W-1:0] clamp_len;
  logic [PAY_W-1:0] pay_mask;
  logic [QW:0]      pend;

  assign do_sub   = cmd.accept && (op == OP_SUBSCRIBE);
  assign do_unsub = cmd.accept && (op == OP_UNSUBSCRIBE);
  assign do_pub   = cmd.accept && (op == OP_PUBLISH);
  assign do_disp  = cmd.accept && (op == OP_DISPATCH);
  assign do_flush = cmd.accept && (op == OP_FLUSH);
  assign do_stats = cmd.accept && (op == OP_STATS);
  assign simple_load = do_sub || do_unsub || do_pub || do_flush || do_stats ||
                       (do_disp && q_empty);

  assign wr_nxt  = (write_index == QW'(QUEUE_DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign rd_nxt  = (read_index == QW'(QUEUE_DEPTH - 1)) ? '0 : read_index + 1'b1;
  assign q_full  = (wr_nxt == read_index);
  assign q_empty = (write_index == read_index);
  assign pend    = (write_index >= read_index)
                 ? {1'b0, write_index} - {1'b0, read_index}
                 : {1'b0, write_index} + (QW+1)'(QUEUE_DEPTH) - {1'b0, read_index};

  // Lowest inactive slot below the used count
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SUBSCRIBERS - 1; i >= 0; i--) begin
      if (!sub_active[i] && (i < int'(slots_used))) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  assign table_full = (slots_used == UW'(SUBSCRIBERS));
  assign new_slot   = free_found ? free_slot : SW'(slots_used);
  assign handle_ok  = int'(handle) < int'(slots_used);

  // Clamp length and mask bytes at and above it
  assign clamp_len = (len_req > PLEN_W'(MAX_PAYLOAD_BYTES))
                   ? LEN_W'(MAX_PAYLOAD_BYTES) : LEN_W'(len_req);
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pay_mask[b*8 +: 8] = (b < int'(clamp_len)) ? 8'hFF : 8'h00;
    end
  end

  // Table state
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_active <= '0;
      slots_used <= '0;
    end else begin
      if (do_sub && (free_found || !table_full)) begin
        sub_active[new_slot] <= 1'b1;
        if (!free_found) begin
          slots_used <= slots_used + 1'b1;
        end
      end
      for (int i = 0; i < SUBSCRIBERS; i++) begin
        if (do_unsub && handle_ok && (int'(handle) == i)) begin
          sub_active[i] <= 1'b0;
        end
      end
    end
  end

  // Table memory: write on subscribe, registered read at the scan slot
  always_ff @(posedge clk) begin
    if (do_sub && (free_found || !table_full)) begin
      sub_event[new_slot] <= ev_code;
      sub_tag[new_slot]   <= tag;
    end
    sub_ev_q  <= sub_event[scan_i];
    sub_tag_q <= sub_tag[scan_i];
  end

  // Ring memory: write on publish, registered read at the read index
  always_ff @(posedge clk) begin
    if (do_pub && !q_full) begin
      queue_event[write_index]   <= ev_code;
      queue_payload[write_index] <= payload & pay_mask;
      queue_length[write_index]  <= clamp_len;
    end
    q_ev_q  <= queue_event[read_index];
    q_pay_q <= queue_payload[read_index];
    q_len_q <= queue_length[read_index];
  end

  // Ring indices and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index      <= '0;
      read_index       <= '0;
      count_published  <= '0;
      count_dispatched <= '0;
      count_dropped    <= '0;
    end else begin
      if (do_pub) begin
        if (q_full) begin
          count_dropped <= count_dropped + 1'b1;
        end else begin
          write_index     <= wr_nxt;
          count_published <= count_published + 1'b1;
        end
      end
      if (cmd.disp_start) begin
        read_index       <= rd_nxt;
        count_dispatched <= count_dispatched + 1'b1;
      end
      if (do_flush) begin
        read_index <= write_index;
      end
    end
  end

  // Scan position, popped event and held delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
      have   <= 1'b0;
      n_cnt  <= '0;
    end else begin
      if (cmd.disp_start) begin
        scan_i <= '0;
        have   <= 1'b0;
        n_cnt  <= '0;
      end
      if (cmd.scan_inc) begin
        scan_i <= scan_i + 1'b1;
      end
      if (cmd.capture) begin
        have  <= 1'b1;
        n_cnt <= n_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_q) begin
      ev_l  <= q_ev_q;
      pay_l <= q_pay_q;
      len_l <= q_len_q;
    end
    if (cmd.capture) begin
      held_slot <= scan_i;
      held_tag  <= sub_tag_q;
    end
  end

  // Result register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (simple_load || cmd.emit_held || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (simple_load) begin
      out_status <= ST_OK;
      out_slot   <= '0;
      out_ev     <= '0;
      out_pay    <= '0;
      out_len    <= '0;
      out_tag_r  <= '0;
      out_last   <= 1'b1;
      if (do_sub) begin
        if (free_found || !table_full) begin
          out_slot <= SLOT_W'(new_slot);
        end else begin
          out_status <= ST_TABLE_FULL;
        end
      end
      if (do_pub && q_full) begin
        out_status <= ST_DROPPED;
      end
      if (do_disp) begin
        out_status <= ST_Q_EMPTY;
      end
    end else if (cmd.emit_held || cmd.emit_final) begin
      out_ev  <= ev_l;
      out_pay <= pay_l;
      out_len <= len_l;
      if (cmd.emit_final && !have) begin
        out_status <= ST_NO_SUB;
        out_slot   <= '0;
        out_tag_r  <= '0;
      end else begin
        out_status <= ST_OK;
        out_slot   <= SLOT_W'(held_slot);
        out_tag_r  <= held_tag;
      end
      out_last <= cmd.emit_final;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.slot             = out_slot;
  assign rsp.out_event_id     = out_ev;
  assign rsp.out_payload      = out_pay;
  assign rsp.out_length       = out_len;
  assign rsp.out_tag          = out_tag_r;
  assign rsp.last             = out_last;
  assign rsp.pending          = PEND_W'(pend);
  assign rsp.published_count  = count_published;
  assign rsp.dispatched_count = count_dispatched;
  assign rsp.dropped_count    = count_dropped;
  assign rsp.subscriber_total = TOT_W'(slots_used);

  // Status to controller
  assign stat.out_free = !out_valid || rsp.ready;
  assign stat.q_empty  = q_empty;
  assign stat.no_subs  = (slots_used == '0);
  assign stat.match    = sub_active[scan_i] && (sub_ev_q == ev_l);
  assign stat.have     = have;
  assign stat.scan_end = ((UW'(scan_i) + 1'b1) == slots_used);
  assign stat.cap_last = stat.scan_end || (n_cnt == NCOUNT_W'(RESULT_LIMIT - 1));

endmodule

// ===== rtl/event_publish_subscribe_router_unit.sv =====
// Top level of the event publish/subscribe router.
// Depends on epsr_pkg, epsr_channel_if, epsr_ctrl and epsr_dpath.
//
// Usage:
//  - req carries one operation per transaction (subscribe, unsubscribe,
//    publish, dispatch one, flush, stats); rsp returns result transactions,
//    with last set on the final result of each operation. Ops 6 and 7 are
//    dropped without a result.
//  - Non-dispatch operations load their result at the accepting edge. A dispatch
//    on a non-empty ring reads the ring entry (S_QRD), then for each used subscriber
//    slot reads the table (S_SRD) and compares (S_SCMP); a match while a delivery
//    is held first sends the held one (S_EMIT). S_FIN sends the final result; at
//    most 16 deliveries.
//  - One operation is in flight at a time. req.ready is high only when idle and
//    the output register is empty or being taken at the same edge, so a result
//    the receiver has not taken holds off the next request.
//  - When the receiver stalls, the output register holds its result and the
//    scan waits at the next delivery.
//  - Synchronous reset clears the active flags, used count, ring indices,
//    counters and output valid; table and ring contents are written before use.
module event_publish_subscribe_router_unit
  import epsr_pkg::*;
#(
  parameter int SUBSCRIBERS       = SUBSCRIBERS_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  epsr_req_if.sink   req,
  epsr_rsp_if.source rsp
);

  epsr_cmd_t  cmd;
  epsr_stat_t stat;
  logic       ready;

  assign req.ready = ready;

  epsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  epsr_dpath #(
    .SUBSCRIBERS       (SUBSCRIBERS),
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .op          (req.op),
    .ev_code     (req.ev_code),
    .handle      (req.handle),
    .payload     (req.payload),
    .len_req     (req.len_req),
    .tag         (req.tag),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp)
  );

endmodule

// ===== tb/tb_event_publish_subscribe_router_unit.sv =====
// Testbench for the event publish/subscribe router: directed and random operations,
// checked against a transaction-level predictor. Depends on epsr_pkg, epsr_channel_if
// and the RTL top level.
`timescale 1ns / 100ps

module tb;
  import epsr_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [EV_W-1:0]   ev;
    logic [PAY_W-1:0]  pay;
    logic [LEN_W-1:0]  len;
    logic [TAG_W-1:0]  tag;
    logic              last;
    logic [PEND_W-1:0] pending;
    logic [CNT_W-1:0]  n_pub;
    logic [CNT_W-1:0]  n_disp;
    logic [CNT_W-1:0]  n_drop;
    logic [TOT_W-1:0]  total;
  } delivery_t;

  // Router predictor and queue of expected deliveries
  class router_scoreboard;
    logic [EV_W-1:0]   sub_ev[16];
    logic [TAG_W-1:0]  sub_tg[16];
    bit                sub_on[16];
    int                used;
    logic [EV_W-1:0]   q_ev[16];
    logic [PAY_W-1:0]  q_pay[16];
    logic [LEN_W-1:0]  q_len[16];
    int                wr, rd;
    logic [CNT_W-1:0]  n_pub, n_disp, n_drop;
    delivery_t         expected[$];
    int                errors;

    function void reset_state();
      foreach (sub_on[i]) sub_on[i] = 0;
      used = 0; wr = 0; rd = 0; n_pub = 0; n_disp = 0; n_drop = 0;
      expected.delete(); errors = 0;
    endfunction

    function void push(logic [ST_W-1:0] st, int sl, logic [EV_W-1:0] e,
                       logic [PAY_W-1:0] p, logic [LEN_W-1:0] l,
                       logic [TAG_W-1:0] t, bit lst);
      delivery_t d;
      d.status = st; d.slot = sl[SLOT_W-1:0]; d.ev = e; d.pay = p; d.len = l; d.tag = t;
      d.last = lst; d.pending = PEND_W'((wr + 16 - rd) % 16);
      d.n_pub = n_pub; d.n_disp = n_disp; d.n_drop = n_drop; d.total = TOT_W'(used);
      expected.push_back(d);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [EV_W-1:0] e,
                               logic [HDL_W-1:0] h, logic [PAY_W-1:0] p,
                               logic [PLEN_W-1:0] pl, logic [TAG_W-1:0] t);
      int hits[$];
      int ln, s;
      logic [PAY_W-1:0] mask;
      case (op)
        OP_SUBSCRIBE: begin
          s = -1;
          for (int i = 0; i < used; i++)
            if (s < 0 && !sub_on[i]) s = i;
          if (s < 0 && used < 16) begin
            s = used; used++;
          end
          if (s < 0) push(ST_TABLE_FULL, 0, 0, 0, 0, 0, 1);
          else begin
            sub_ev[s] = e; sub_tg[s] = t; sub_on[s] = 1;
            push(ST_OK, s, 0, 0, 0, 0, 1);
          end
        end
        OP_UNSUBSCRIBE: begin
          if (h < used) sub_on[h] = 0;
          push(ST_OK, 0, 0, 0, 0, 0, 1);
        end
        OP_PUBLISH: begin
          if ((wr + 1) % 16 == rd) begin
            n_drop++;
            push(ST_DROPPED, 0, 0, 0, 0, 0, 1);
          end else begin
            ln = (pl > 8) ? 8 : pl;
            mask = (ln == 8) ? '1 : ((64'd1 << (8 * ln)) - 1);
            q_ev[wr] = e; q_pay[wr] = p & mask; q_len[wr] = LEN_W'(ln);
            wr = (wr + 1) % 16; n_pub++;
            push(ST_OK, 0, 0, 0, 0, 0, 1);
          end
        end
        OP_DISPATCH: begin
          if (rd == wr) push(ST_Q_EMPTY, 0, 0, 0, 0, 0, 1);
          else begin
            for (int i = 0; i < used; i++)
              if (sub_on[i] && sub_ev[i] == q_ev[rd] && hits.size() < RESULT_LIMIT)
                hits.push_back(i);
            s = rd;
            rd = (rd + 1) % 16; n_disp++;
            if (hits.size() == 0) push(ST_NO_SUB, 0, q_ev[s], q_pay[s], q_len[s], 0, 1);
            foreach (hits[k])
              push(ST_OK, hits[k], q_ev[s], q_pay[s], q_len[s], sub_tg[hits[k]],
                   k == hits.size() - 1);
          end
        end
        OP_FLUSH: begin
          rd = wr;
          push(ST_OK, 0, 0, 0, 0, 0, 1);
        end
        OP_STATS: push(ST_OK, 0, 0, 0, 0, 0, 1);
        default: ;
      endcase
    endfunction

    function void check_result(delivery_t got);
      delivery_t w;
      if (expected.size() == 0) begin
        $error("unexpected result transaction status=%0d", got.status);
        errors++;
        return;
      end
      w = expected.pop_front();
      if (got.status !== w.status) begin
        $error("status exp %0h got %0h", w.status, got.status); errors++;
      end
      if (got.slot !== w.slot) begin
        $error("slot exp %0h got %0h", w.slot, got.slot); errors++;
      end
      if (got.ev !== w.ev) begin
        $error("out_event_id exp %0h got %0h", w.ev, got.ev); errors++;
      end
      if (got.pay !== w.pay) begin
        $error("out_payload exp %0h got %0h", w.pay, got.pay); errors++;
      end
      if (got.len !== w.len) begin
        $error("out_length exp %0h got %0h", w.len, got.len); errors++;
      end
      if (got.tag !== w.tag) begin
        $error("out_tag exp %0h got %0h", w.tag, got.tag); errors++;
      end
      if (got.last !== w.last) begin
        $error("last exp %0h got %0h", w.last, got.last); errors++;
      end
      if (got.pending !== w.pending) begin
        $error("pending exp %0h got %0h", w.pending, got.pending); errors++;
      end
      if (got.n_pub !== w.n_pub) begin
        $error("published_count exp %0h got %0h", w.n_pub, got.n_pub); errors++;
      end
      if (got.n_disp !== w.n_disp) begin
        $error("dispatched_count exp %0h got %0h", w.n_disp, got.n_disp); errors++;
      end
      if (got.n_drop !== w.n_drop) begin
        $error("dropped_count exp %0h got %0h", w.n_drop, got.n_drop); errors++;
      end
      if (got.total !== w.total) begin
        $error("subscriber_total exp %0h got %0h", w.total, got.total); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  epsr_req_if req ();
  epsr_rsp_if rsp ();
  router_scoreboard sb;
  int send_idle, recv_idle;
  bit hold_off;
  longint cycles;

  event_publish_subscribe_router_unit uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Sample result transactions and check them
  always @(posedge clk) begin
    delivery_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.slot, rsp.out_event_id, rsp.out_payload, rsp.out_length,
             rsp.out_tag, rsp.last, rsp.pending, rsp.published_count,
             rsp.dispatched_count, rsp.dropped_count, rsp.subscriber_total};
      sb.check_result(got);
    end
  end

  // Receiver ready, with random stalls and a long hold-off on request
  initial begin
    rsp.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp.ready <= 0;
        repeat (120) @(negedge clk);
        hold_off = 0;
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one request and hold it until accepted; the next call or drain
  // drives valid at the following falling edge
  task automatic send_req(logic [OP_W-1:0] op, logic [EV_W-1:0] e, logic [HDL_W-1:0] h,
                          logic [PAY_W-1:0] p, logic [PLEN_W-1:0] pl,
                          logic [TAG_W-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 0;
      @(negedge clk);
    end
    req.valid <= 1; req.op <= op; req.ev_code <= e; req.handle <= h;
    req.payload <= p; req.len_req <= pl; req.tag <= t;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, e, h, p, pl, t);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Random operation, weighted toward useful traffic on a small id space
  task automatic send_random();
    int r;
    logic [OP_W-1:0] op;
    logic [EV_W-1:0] e;
    r = $urandom_range(99);
    if (r < 15) op = OP_SUBSCRIBE;
    else if (r < 25) op = OP_UNSUBSCRIBE;
    else if (r < 55) op = OP_PUBLISH;
    else if (r < 88) op = OP_DISPATCH;
    else if (r < 92) op = OP_FLUSH;
    else if (r < 97) op = OP_STATS;
    else op = OP_W'($urandom_range(7, 6));
    e = ($urandom_range(9) == 0) ? EV_W'($urandom) : EV_W'($urandom_range(3));
    send_req(op, e, HDL_W'($urandom), {$urandom, $urandom}, PLEN_W'($urandom_range(12)),
             $urandom);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    send_idle = 0; recv_idle = 0; hold_off = 0;
    req.valid = 0; req.op = OP_STATS; req.ev_code = 0; req.handle = 0;
    req.payload = 0; req.len_req = 0; req.tag = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty queue, table fill and overflow, clamp, no match, full ring
    send_req(OP_DISPATCH, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_req(OP_SUBSCRIBE, 8'hFF, 0, 0, 0, 32'hFFFF_FFF0 + i);
    send_req(OP_UNSUBSCRIBE, 0, 4'd3, 0, 0, 0);
    send_req(OP_SUBSCRIBE, 8'h00, 0, 0, 0, 32'h0);
    send_req(OP_PUBLISH, 8'hFF, 0, '1, 8'hFF, 0);
    send_req(OP_PUBLISH, 8'h00, 0, '1, 8'd0, 0);
    send_req(OP_PUBLISH, 8'h42, 0, 64'h0123_4567_89AB_CDEF, 8'd3, 0);
    send_req(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_req(OP_DISPATCH, 0, 0, 0, 0, 0);
    send_req(OP_DISPATCH, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) send_req(OP_PUBLISH, 8'h01, 0, {$urandom, $urandom}, 8, 0);
    send_req(OP_STATS, 0, 0, 0, 0, 0);
    send_req(OP_FLUSH, 0, 0, 0, 0, 0);
    send_req(3'd6, 0, 0, 0, 0, 0);
    send_req(3'd7, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) send_req(OP_UNSUBSCRIBE, 0, HDL_W'(i), 0, 0, 0);
    drain();

    // Random phases with differing stall patterns
    send_idle = 21; recv_idle = 82;
    for (int i = 0; i < 50; i++) send_random();
    drain();
    send_idle = 82; recv_idle = 21;
    for (int i = 0; i < 40; i++) send_random();
    drain();
    send_idle = 0; recv_idle = 0;
    hold_off = 1;
    for (int i = 0; i < 50; i++) send_random();
    drain();

    if (sb.errors == 0 && sb.expected.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/epsr_pkg.sv
rtl/epsr_channel_if.sv
rtl/epsr_ctrl.sv
rtl/epsr_dpath.sv
rtl/event_publish_subscribe_router_unit.sv
tb/tb_event_publish_subscribe_router_unit.sv
